// ===== rtl/ctep_pkg.sv =====
// shared constants, register codes and the arctangent table for the
// cube tile to equirectangular pixel core; no dependencies
package ctep_pkg;

	localparam int MAX_LEVEL_DEF   = 15;
	localparam int PIX_FRAC_DEF    = 8;
	localparam int CORDIC_STAGES_DEF = 18;

	// cordic datapath and angle widths, angle unit is 2^-32 turn
	localparam int CW = 34;
	localparam int AW = 34;

	// integer square root: one result bit per step
	localparam int SQ_STEPS = 32;
	localparam int SQW      = 64;

	// normalized magnitude width
	localparam int NMW = 30;

	localparam int WIDTH_W  = 15;
	localparam int HEIGHT_W = 14;
	localparam int PIXX_W   = 22;
	localparam int PIXY_W   = 21;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 15'd4096;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 14'd2048;

	// register index taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] v;
		begin
			case (idx)
				0:  v = 32'd536870912;
				1:  v = 32'd316933406;
				2:  v = 32'd167458907;
				3:  v = 32'd85004756;
				4:  v = 32'd42667331;
				5:  v = 32'd21354465;
				6:  v = 32'd10679838;
				7:  v = 32'd5340245;
				8:  v = 32'd2670163;
				9:  v = 32'd1335087;
				10: v = 32'd667544;
				11: v = 32'd333772;
				12: v = 32'd166886;
				13: v = 32'd83443;
				14: v = 32'd41722;
				15: v = 32'd20861;
				16: v = 32'd10430;
				17: v = 32'd5215;
				18: v = 32'd2608;
				19: v = 32'd1304;
				20: v = 32'd652;
				21: v = 32'd326;
				22: v = 32'd163;
				23: v = 32'd81;
				24: v = 32'd41;
				25: v = 32'd20;
				26: v = 32'd10;
				27: v = 32'd5;
				28: v = 32'd3;
				29: v = 32'd1;
				30: v = 32'd1;
				default: v = 32'd0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== rtl/cube_tile_to_equirect_pixel_core.sv =====
// cube tile point to equirectangular pixel: face point, normalize, cordic
// longitude, square root, cordic latitude, pixel mapping
// depends on ctep_pkg, ctep_cordic_cell, ctep_sqrt_cell
//
// channel  dir  width  contents
// s_axis   in   80     cube_face, tile_level, tile_x, tile_y, offset_x, offset_y
// m_axis   out  48     pixel_x, pixel_y
// apb      in   32     0x0 image_width, 0x4 image_height
//
// one transaction per cycle sustained while no result waits on m_axis_tready; the
// pipeline runs through the two cordic rows and the 32-step square root row
// reset clears all valid bits and loads the default image size
// the whole pipeline holds while a result waits on m_axis_tready
module cube_tile_to_equirect_pixel_core #(
	parameter int MAX_LEVEL           = ctep_pkg::MAX_LEVEL_DEF,
	parameter int PIXEL_FRACTION_BITS = ctep_pkg::PIX_FRAC_DEF,
	parameter int CORDIC_STAGES       = ctep_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cube_face[2:0], tile_level[6:3], tile_x[21:7], tile_y[36:22],
	// offset_x[54:37], offset_y[72:55]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_x[21:0], pixel_y[42:22]
	output logic [47:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ctep_pkg::*;

	localparam int PW  = ((MAX_LEVEL + 16 > 32) ? MAX_LEVEL + 16 : 32) + 3;
	localparam int MW  = PW - 1;
	localparam int BLW = $clog2(MW + 1);
	localparam int LSW = 31 + NMW + NMW + 1;
	localparam int QSW = 31 + 32;
	localparam int BW  = AW + 2;
	localparam int PXW = 47 + PIXEL_FRACTION_BITS;
	localparam int PYW = 47 + PIXEL_FRACTION_BITS;

	// configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = 32'd0;
		endcase
	end

	// pipeline enable
	logic en;
	logic out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: face point and axis rotation
	logic [2:0]             in_face;
	logic [3:0]             in_lvl;
	logic [14:0]            in_tx;
	logic [14:0]            in_ty;
	logic signed [17:0]     in_ox;
	logic signed [17:0]     in_oy;
	logic [3:0]             lvl_c;
	logic signed [PW-1:0]   fs;
	logic signed [PW-1:0]   p0;
	logic signed [PW-1:0]   p1;
	logic signed [PW-1:0]   p2;
	logic                   mirror;
	logic signed [PW-1:0]   rx;
	logic signed [PW-1:0]   ry;
	logic signed [PW-1:0]   rz;

	assign in_face = s_axis_tdata[2:0];
	assign in_lvl  = s_axis_tdata[6:3];
	assign in_tx   = s_axis_tdata[21:7];
	assign in_ty   = s_axis_tdata[36:22];
	assign in_ox   = signed'(s_axis_tdata[54:37]);
	assign in_oy   = signed'(s_axis_tdata[72:55]);

	always_comb begin
		lvl_c  = (int'(in_lvl) > MAX_LEVEL) ? 4'(MAX_LEVEL) : in_lvl;
		fs     = signed'(PW'(1) << (5'(lvl_c) + 5'd16));
		mirror = in_face >= 3'd3;
		p0 = ((PW'(in_ox) + (signed'(PW'(in_tx)) <<< 16)) <<< 1) - fs;
		p1 = ((PW'(in_oy) + (signed'(PW'(in_ty)) <<< 16)) <<< 1) - fs;
		p2 = fs;
		if (mirror) begin
			p0 = -p0;
			p2 = -p2;
		end
		case (in_face) inside
			3'd0, 3'd3, 3'd6: begin
				rx = p0; ry = p1; rz = p2;
			end
			3'd1, 3'd4, 3'd7: begin
				rx = p1; ry = p2; rz = p0;
			end
			default: begin
				rx = p2; ry = p0; rz = p1;
			end
		endcase
	end

	logic                 v_s1;
	logic signed [PW-1:0] x_s1;
	logic signed [PW-1:0] y_s1;
	logic signed [PW-1:0] z_s1;

	// stage 2: magnitudes
	logic          v_s2;
	logic [MW-1:0] ax_s2, ay_s2, az_s2;
	logic          sx_s2, sy_s2, sz_s2;

	// stage 3: largest magnitude
	logic          v_s3;
	logic [MW-1:0] ax_s3, ay_s3, az_s3, m_s3;
	logic          sx_s3, sy_s3, sz_s3;

	// stage 4: bit length
	logic           v_s4;
	logic [MW-1:0]  ax_s4, ay_s4, az_s4;
	logic           sx_s4, sy_s4, sz_s4;
	logic [BLW-1:0] bl_s4;
	logic [BLW-1:0] bl_c;

	always_comb begin
		bl_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (m_s3[i]) bl_c = BLW'(i + 1);
		end
	end

	// stage 5: normalized magnitudes
	logic           v_s5;
	logic [NMW-1:0] ax_s5, ay_s5, az_s5;
	logic           sx_s5, sy_s5, sz_s5;

	function automatic logic [NMW-1:0] renorm(input logic [MW-1:0] m,
	                                           input logic [BLW-1:0] bl);
		logic [MW-1:0] r;
		begin
			if (bl >= BLW'(NMW)) r = m >> (bl - BLW'(NMW));
			else                 r = m << (BLW'(NMW) - bl);
			return r[NMW-1:0];
		end
	endfunction

	// stage 6: cordic setup for the longitude
	logic                 v_s6;
	logic signed [CW-1:0] cx_s6, cy_s6;
	logic signed [AW-1:0] ang_s6;
	logic [LSW-1:0]       side_s6;
	logic signed [30:0]   ny_c;
	logic                 xneg_c, zneg_c, pole_c;

	assign ny_c   = sy_s5 ? -signed'(31'(ay_s5)) : signed'(31'(ay_s5));
	assign xneg_c = sx_s5 && (ax_s5 != '0);
	assign zneg_c = sz_s5 && (az_s5 != '0);
	assign pole_c = (ax_s5 == '0) && (az_s5 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= rx;
			y_s1 <= ry;
			z_s1 <= rz;

			sx_s2 <= x_s1[PW-1];
			sy_s2 <= y_s1[PW-1];
			sz_s2 <= z_s1[PW-1];
			ax_s2 <= x_s1[PW-1] ? MW'(-x_s1) : MW'(x_s1);
			ay_s2 <= y_s1[PW-1] ? MW'(-y_s1) : MW'(y_s1);
			az_s2 <= z_s1[PW-1] ? MW'(-z_s1) : MW'(z_s1);

			{sx_s3, sy_s3, sz_s3} <= {sx_s2, sy_s2, sz_s2};
			{ax_s3, ay_s3, az_s3} <= {ax_s2, ay_s2, az_s2};
			if (ax_s2 >= ay_s2 && ax_s2 >= az_s2) m_s3 <= ax_s2;
			else if (ay_s2 >= az_s2)              m_s3 <= ay_s2;
			else                                  m_s3 <= az_s2;

			{sx_s4, sy_s4, sz_s4} <= {sx_s3, sy_s3, sz_s3};
			{ax_s4, ay_s4, az_s4} <= {ax_s3, ay_s3, az_s3};
			bl_s4 <= bl_c;

			{sx_s5, sy_s5, sz_s5} <= {sx_s4, sy_s4, sz_s4};
			ax_s5 <= renorm(ax_s4, bl_s4);
			ay_s5 <= renorm(ay_s4, bl_s4);
			az_s5 <= renorm(az_s4, bl_s4);

			side_s6 <= {ny_c, ax_s5, az_s5, pole_c};
			if (xneg_c) begin
				cx_s6  <= signed'(CW'(ax_s5));
				cy_s6  <= zneg_c ? signed'(CW'(az_s5)) : -signed'(CW'(az_s5));
				ang_s6 <= zneg_c ? -(signed'(AW'(1)) <<< 31) : (signed'(AW'(1)) <<< 31);
			end else begin
				cx_s6  <= signed'(CW'(ax_s5));
				cy_s6  <= zneg_c ? -signed'(CW'(az_s5)) : signed'(CW'(az_s5));
				ang_s6 <= '0;
			end
		end
	end

	// longitude cordic row
	logic                 lv  [0:CORDIC_STAGES];
	logic signed [CW-1:0] lx  [0:CORDIC_STAGES];
	logic signed [CW-1:0] ly  [0:CORDIC_STAGES];
	logic signed [AW-1:0] la  [0:CORDIC_STAGES];
	logic [LSW-1:0]       ls  [0:CORDIC_STAGES];

	assign lv[0] = v_s6;
	assign lx[0] = cx_s6;
	assign ly[0] = cy_s6;
	assign la[0] = ang_s6;
	assign ls[0] = side_s6;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lon
		ctep_cordic_cell #(.IDX(i), .SW(LSW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (lv[i]),
			.x_i    (lx[i]),
			.y_i    (ly[i]),
			.ang_i  (la[i]),
			.side_i (ls[i]),
			.vld_o  (lv[i+1]),
			.x_o    (lx[i+1]),
			.y_o    (ly[i+1]),
			.ang_o  (la[i+1]),
			.side_o (ls[i+1])
		);
	end

	// squares and the shifted longitude
	logic [LSW-1:0]       lend;
	logic signed [30:0]   lny;
	logic [NMW-1:0]       lax, laz;
	logic                 lpole;
	logic signed [AW-1:0] lon_c;
	logic signed [AW-1:0] lsum_c;

	assign lend                   = ls[CORDIC_STAGES];
	assign {lny, lax, laz, lpole} = lend;
	assign lon_c  = lpole ? '0 : la[CORDIC_STAGES];
	assign lsum_c = lon_c + (signed'(AW'(1)) <<< 31);

	logic               v_q1, v_q2;
	logic [2*NMW-1:0]   sqx_q1, sqz_q1;
	logic [QSW-1:0]     side_q1, side_q2;
	logic [2*NMW:0]     n_q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q1 <= 1'b0;
			v_q2 <= 1'b0;
		end else if (en) begin
			v_q1 <= lv[CORDIC_STAGES];
			v_q2 <= v_q1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_q1  <= lax * lax;
			sqz_q1  <= laz * laz;
			side_q1 <= {lny, lsum_c[31:0]};
			n_q2    <= (2*NMW+1)'(sqx_q1) + (2*NMW+1)'(sqz_q1);
			side_q2 <= side_q1;
		end
	end

	// square root row
	logic           qv [0:SQ_STEPS];
	logic [SQW-1:0] qn [0:SQ_STEPS];
	logic [SQW-1:0] qr [0:SQ_STEPS];
	logic [QSW-1:0] qs [0:SQ_STEPS];

	assign qv[0] = v_q2;
	assign qn[0] = SQW'(n_q2);
	assign qr[0] = '0;
	assign qs[0] = side_q2;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		ctep_sqrt_cell #(.K(SQ_STEPS - 1 - j), .SW(QSW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (qv[j]),
			.n_i    (qn[j]),
			.res_i  (qr[j]),
			.side_i (qs[j]),
			.vld_o  (qv[j+1]),
			.n_o    (qn[j+1]),
			.res_o  (qr[j+1]),
			.side_o (qs[j+1])
		);
	end

	// latitude cordic row
	logic signed [30:0]   qny;
	logic [31:0]          qlon;
	logic                 tv  [0:CORDIC_STAGES];
	logic signed [CW-1:0] tx  [0:CORDIC_STAGES];
	logic signed [CW-1:0] ty  [0:CORDIC_STAGES];
	logic signed [AW-1:0] ta  [0:CORDIC_STAGES];
	logic [31:0]          ts  [0:CORDIC_STAGES];

	assign {qny, qlon} = qs[SQ_STEPS];
	assign tv[0] = qv[SQ_STEPS];
	assign tx[0] = signed'(CW'(qr[SQ_STEPS][30:0]));
	assign ty[0] = CW'(qny);
	assign ta[0] = '0;
	assign ts[0] = qlon;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lat
		ctep_cordic_cell #(.IDX(i), .SW(32)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (tv[i]),
			.x_i    (tx[i]),
			.y_i    (ty[i]),
			.ang_i  (ta[i]),
			.side_i (ts[i]),
			.vld_o  (tv[i+1]),
			.x_o    (tx[i+1]),
			.y_o    (ty[i+1]),
			.ang_o  (ta[i+1]),
			.side_o (ts[i+1])
		);
	end

	// pixel mapping
	logic signed [BW-1:0] bsum_c;
	logic [32:0]          bcl_c;

	assign bsum_c = (BW'(ta[CORDIC_STAGES]) <<< 1) + (signed'(BW'(1)) <<< 31);

	always_comb begin
		if (bsum_c < 0)                             bcl_c = '0;
		else if (bsum_c > (signed'(BW'(1)) <<< 32)) bcl_c = 33'h1_0000_0000;
		else                                        bcl_c = bsum_c[32:0];
	end

	logic        v_t1, v_t2;
	logic [31:0] a_t1;
	logic [32:0] b_t1;
	logic [46:0] prx_t2, pry_t2;

	logic [PXW-1:0] pxs_c;
	logic [PYW-1:0] pys_c, plim_c, py_c;

	assign pxs_c  = (PXW'(prx_t2) << PIXEL_FRACTION_BITS) >> 32;
	assign pys_c  = (PYW'(pry_t2) << PIXEL_FRACTION_BITS) >> 32;
	assign plim_c = PYW'(height_q - HEIGHT_W'(1)) << PIXEL_FRACTION_BITS;

	always_comb begin
		if (height_q == '0)     py_c = '0;
		else if (pys_c > plim_c) py_c = plim_c;
		else                     py_c = pys_c;
	end

	logic [PIXX_W-1:0] px_q;
	logic [PIXY_W-1:0] py_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1      <= 1'b0;
			v_t2      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_t1      <= tv[CORDIC_STAGES];
			v_t2      <= v_t1;
			out_vld_q <= v_t2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_t1   <= ts[CORDIC_STAGES];
			b_t1   <= bcl_c;
			prx_t2 <= 47'(a_t1 * width_q);
			pry_t2 <= 47'(b_t1 * height_q);
			px_q   <= pxs_c[PIXX_W-1:0];
			py_q   <= py_c[PIXY_W-1:0];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, py_q, px_q};

	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted transaction did not enter the pipeline");

	a_norm_top_bit : assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (ax_s5[NMW-1] || ay_s5[NMW-1] || az_s5[NMW-1]))
		else $error("normalized vector lost its top bit");

	a_stall_only_full : assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("pipeline stalled without a waiting result");

endmodule

// ===== rtl/ctep_cordic_cell.sv =====
// one vectoring cordic iteration with a fixed shift, plus a side payload
// depends on ctep_pkg
module ctep_cordic_cell #(
	parameter int IDX = 0,
	parameter int SW  = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_i,
	input  logic signed [ctep_pkg::CW-1:0]  x_i,
	input  logic signed [ctep_pkg::CW-1:0]  y_i,
	input  logic signed [ctep_pkg::AW-1:0]  ang_i,
	input  logic [SW-1:0]                   side_i,
	output logic                            vld_o,
	output logic signed [ctep_pkg::CW-1:0]  x_o,
	output logic signed [ctep_pkg::CW-1:0]  y_o,
	output logic signed [ctep_pkg::AW-1:0]  ang_o,
	output logic [SW-1:0]                   side_o
);
	import ctep_pkg::*;

	localparam logic signed [AW-1:0] STEP = signed'(AW'(atan_turn(IDX)));

	logic                 vld_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [AW-1:0] ang_q;
	logic [SW-1:0]        side_q;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	assign dx = y_i >>> IDX;
	assign dy = x_i >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (!y_i[CW-1]) begin
				x_q   <= x_i + dx;
				y_q   <= y_i - dy;
				ang_q <= ang_i + STEP;
			end else begin
				x_q   <= x_i - dx;
				y_q   <= y_i + dy;
				ang_q <= ang_i - STEP;
			end
		end
	end

	assign vld_o  = vld_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign ang_o  = ang_q;
	assign side_o = side_q;

endmodule

// ===== rtl/ctep_sqrt_cell.sv =====
// one step of the bitwise integer square root, plus a side payload
// depends on ctep_pkg
module ctep_sqrt_cell #(
	parameter int K  = 0,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [ctep_pkg::SQW-1:0]   n_i,
	input  logic [ctep_pkg::SQW-1:0]   res_i,
	input  logic [SW-1:0]              side_i,
	output logic                       vld_o,
	output logic [ctep_pkg::SQW-1:0]   n_o,
	output logic [ctep_pkg::SQW-1:0]   res_o,
	output logic [SW-1:0]              side_o
);
	import ctep_pkg::*;

	localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

	logic           vld_q;
	logic [SQW-1:0] n_q;
	logic [SQW-1:0] res_q;
	logic [SW-1:0]  side_q;
	logic [SQW-1:0] trial;

	assign trial = res_i + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (n_i >= trial) begin
				n_q   <= n_i - trial;
				res_q <= (res_i >> 1) + BIT;
			end else begin
				n_q   <= n_i;
				res_q <= res_i >> 1;
			end
		end
	end

	assign vld_o  = vld_q;
	assign n_o    = n_q;
	assign res_o  = res_q;
	assign side_o = side_q;

endmodule

// ===== tb/sv/tb.sv =====
// testbench for cube_tile_to_equirect_pixel_core: a queue-fed stream driver, a monitor
// that checks each pixel against an in-bench fixed point cordic projection, apb image setup
// depends on ctep_pkg and the core rtl
`timescale 1ns / 100ps

module tb;
	import ctep_pkg::*;

	typedef struct packed {
		logic [2:0]  face;
		logic [3:0]  level;
		logic [14:0] tx;
		logic [14:0] ty;
		logic [17:0] ox;
		logic [17:0] oy;
	} tile_point_t;

	typedef struct packed {
		logic [PIXY_W-1:0] py;
		logic [PIXX_W-1:0] px;
	} pixel_t;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tile_point_t pending_points[$];
	pixel_t expected_pixels[$];
	logic [WIDTH_W-1:0] img_width = WIDTH_RST;
	logic [HEIGHT_W-1:0] img_height = HEIGHT_RST;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int points_sent = 0;
	int pixels_checked = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	cube_tile_to_equirect_pixel_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	function automatic longint vector_angle(longint vx, longint vy, longint start);
		longint ang;
		longint dx;
		longint dy;
		ang = start;
		for (int i = 0; i < STAGES && i < 32; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; ang += longint'(atan_turn(i));
			end else begin
				vx -= dx; vy += dy; ang -= longint'(atan_turn(i));
			end
		end
		return ang;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint normalize(longint v, int sh);
		longint m;
		m = magnitude(v);
		m = sh >= 0 ? (m >> sh) : (m << (-sh));
		return v < 0 ? -m : m;
	endfunction

	function automatic pixel_t project_point(tile_point_t t);
		int lvl;
		int k;
		int sh;
		int bl;
		longint f;
		longint p[3];
		longint vx, vy, vz, lon, lat, b, m;
		longint unsigned r, a, px, py;
		pixel_t res;
		lvl = t.level > MAX_LEVEL_DEF ? MAX_LEVEL_DEF : int'(t.level);
		f = 64'sd1 << (lvl + 16);
		p[0] = 2 * (longint'($signed(t.ox)) + longint'(t.tx) * 65536) - f;
		p[1] = 2 * (longint'($signed(t.oy)) + longint'(t.ty) * 65536) - f;
		p[2] = f;
		if (t.face >= 3) begin
			p[0] = -p[0];
			p[2] = -p[2];
		end
		k = t.face % 3;
		vx = p[k];
		vy = p[(k + 1) % 3];
		vz = p[(k + 2) % 3];
		m = magnitude(vx);
		if (magnitude(vy) > m) m = magnitude(vy);
		if (magnitude(vz) > m) m = magnitude(vz);
		bl = 0;
		while (bl < 64 && (m >> bl) != 0) bl++;
		sh = bl - NMW;
		vx = normalize(vx, sh);
		vy = normalize(vy, sh);
		vz = normalize(vz, sh);
		if (vx == 0 && vz == 0)
			lon = 0;
		else if (vx < 0)
			lon = vector_angle(-vx, -vz, vz >= 0 ? (64'sd1 << 31) : -(64'sd1 << 31));
		else
			lon = vector_angle(vx, vz, 0);
		r = root_floor(longint'(magnitude(vx) * magnitude(vx) + magnitude(vz) * magnitude(vz)));
		lat = vector_angle(longint'(r), vy, 0);
		a = longint'(lon + (64'sd1 << 31)) & 64'hFFFF_FFFF;
		px = ((a * img_width) << PIX_FRAC_DEF) >> 32;
		b = 2 * lat + (64'sd1 << 31);
		if (b < 0) b = 0;
		if (b > (64'sd1 << 32)) b = 64'sd1 << 32;
		if (img_height == 0) begin
			py = 0;
		end else begin
			py = ((longint'(b) * img_height) << PIX_FRAC_DEF) >> 32;
			if (py > (longint'(img_height - 1) << PIX_FRAC_DEF))
				py = longint'(img_height - 1) << PIX_FRAC_DEF;
		end
		res.px = px[PIXX_W-1:0];
		res.py = py[PIXY_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_pixels.push_back(project_point(pending_points[0]));
				void'(pending_points.pop_front());
				points_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the transaction
			end else if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'd0, pending_points[0].oy, pending_points[0].ox,
					pending_points[0].ty, pending_points[0].tx,
					pending_points[0].level, pending_points[0].face};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[42:0];
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected transaction", got, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (got.px !== want.px) report_mismatch("pixel_x", got.px, want.px);
					if (got.py !== want.py) report_mismatch("pixel_y", got.py, want.py);
				end
				pixels_checked++;
			end
			m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				idle_cycles <= 0;
			else if (pending_points.size() > 0 || expected_pixels.size() > 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL cube_tile_to_equirect_pixel_core");
				$finish;
			end
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_image(int w, int h);
		apb_write({REG_WIDTH, 2'b00}, w);
		apb_write({REG_HEIGHT, 2'b00}, h);
		img_width = w[WIDTH_W-1:0];
		img_height = h[HEIGHT_W-1:0];
	endtask

	task automatic add_point(int face, int level, int tx, int ty, int ox, int oy);
		tile_point_t t;
		t.face = 3'(face); t.level = 4'(level); t.tx = 15'(tx); t.ty = 15'(ty);
		t.ox = 18'(ox); t.oy = 18'(oy);
		pending_points.push_back(t);
	endtask

	task automatic add_random_points(int n);
		int lvl;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85) begin
				lvl = $urandom_range(15);
				add_point($urandom_range(5), lvl, $urandom_range((1 << lvl) - 1),
					$urandom_range((1 << lvl) - 1),
					int'($urandom_range(72090)) - 6554, int'($urandom_range(72090)) - 6554);
			end else begin
				add_point($urandom_range(7), $urandom_range(15), $urandom_range(32767),
					$urandom_range(32767), $urandom_range(262143), $urandom_range(262143));
			end
		end
	endtask

	task automatic drain();
		wait (pending_points.size() == 0 && expected_pixels.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		int widths[7] = '{4096, 1, 16384, 0, 32767, 360, 0};
		int heights[7] = '{2048, 1, 8192, 0, 16383, 180, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// extremes of the fields, all faces, the pole and tiles off the face
		for (int fc = 0; fc < 8; fc++) add_point(fc, 0, 0, 0, 0, 0);
		add_point(1, 0, 0, 0, 32768, 32768);
		add_point(4, 0, 0, 0, 32768, 32768);
		add_point(0, 15, 32767, 32767, 131071, 131071);
		add_point(3, 15, 0, 0, -65536, -65536);
		add_point(2, 15, 16384, 16384, 0, 0);
		add_point(5, 0, 0, 0, -65536, 131071);
		add_point(1, 3, 100, 32767, 65536, 0);
		add_point(2, 7, 127, 0, 65535, 65535);
		add_point(0, 1, 1, 1, 0, 0);
		add_point(4, 15, 32767, 0, 131071, -65536);
		add_point(6, 10, 1023, 512, 1, 1);
		add_point(7, 15, 32767, 32767, -1, -1);
		add_point(1, 0, 0, 0, 0, 131071);
		add_point(1, 0, 0, 0, 131071, 0);
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			if (ph == 6) set_image($urandom_range(32767), $urandom_range(16383));
			else set_image(widths[ph], heights[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			add_random_points(ph == 0 ? 200 : 240);
		end
		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d tile points over 7 image sizes, %0d pixels checked", points_sent,
			pixels_checked);
		$display("all faces incl. unused codes, pole, off-face tiles and zero-size images");
		if (error_count == 0 && expected_pixels.size() == 0) begin
			$display("PASS cube_tile_to_equirect_pixel_core");
		end else begin
			$display("FAIL cube_tile_to_equirect_pixel_core");
		end
		$finish;
	end

endmodule

// ===== cube_tile_to_equirect_pixel_core.f =====
rtl/ctep_pkg.sv
rtl/ctep_cordic_cell.sv
rtl/ctep_sqrt_cell.sv
rtl/cube_tile_to_equirect_pixel_core.sv
tb/sv/tb.sv
